/* design/pirl_pkg.sv */
// Shared types and constants for the positional insert/remove list.
// Used by the channel interfaces, the cell, the controller and the top level.
package pirl_pkg;

  localparam int unsigned OPC_W     = 2;
  localparam int unsigned POS_W     = 7;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned ST_W      = 2;
  localparam int unsigned DEPTH_DEF = 64;

  localparam logic [OPC_W-1:0] OP_INSERT  = 2'd0;
  localparam logic [OPC_W-1:0] OP_REMOVE  = 2'd1;
  localparam logic [OPC_W-1:0] OP_INSPECT = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  typedef logic signed [KEY_W-1:0] key_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic             ins_en;
    logic             rem_en;
    logic [POS_W-1:0] pos;
    key_t             key;
  } cmd_t;

  typedef struct packed {
    key_t             key_out;
    logic [POS_W-1:0] position_out;
    logic [CNT_W-1:0] count;
    logic             is_empty;
    logic [ST_W-1:0]  status;
  } res_t;

endpackage

/* design/pirl_if.sv */
// Valid/ready channel interfaces for requests and results of the list.
// Depends on pirl_pkg for field widths and types.
interface pirl_in_if;
  logic                         valid;
  logic                         ready;
  logic [pirl_pkg::OPC_W-1:0]   opcode;
  logic [pirl_pkg::POS_W-1:0]   position;
  pirl_pkg::key_t               key_in;

  modport source (output valid, output opcode, output position, output key_in, input ready);
  modport sink   (input valid, input opcode, input position, input key_in, output ready);
endinterface

interface pirl_out_if;
  logic                         valid;
  logic                         ready;
  pirl_pkg::key_t               key_out;
  logic [pirl_pkg::POS_W-1:0]   position_out;
  logic [pirl_pkg::CNT_W-1:0]   count;
  logic                         is_empty;
  logic [pirl_pkg::ST_W-1:0]    status;

  modport source (output valid, output key_out, output position_out, output count,
                  output is_empty, output status, input ready);
  modport sink   (input valid, input key_out, input position_out, input count,
                  input is_empty, input status, output ready);
endinterface

/* design/pirl_cell.sv */
// One storage cell of the list chain: holds a key and shifts, loads or holds.
// Depends on pirl_pkg for the command type.
module pirl_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned AW  = 8
) (
  input  logic           clk,
  input  pirl_pkg::cmd_t cmd,
  input  pirl_pkg::key_t left_key,
  input  pirl_pkg::key_t right_key,
  output pirl_pkg::key_t key_q,
  output pirl_pkg::key_t hit_key
);
  import pirl_pkg::*;

  localparam logic [AW-1:0] MyIdx = AW'(IDX);

  key_t          key_r;
  key_t          key_nxt;
  logic [AW-1:0] posx;

  assign posx = AW'(cmd.pos);

  always_comb begin
    key_nxt = key_r;
    if (cmd.ins_en && (MyIdx > posx)) begin
      key_nxt = left_key;
    end else if (cmd.ins_en && (MyIdx == posx)) begin
      key_nxt = cmd.key;
    end else if (cmd.rem_en && (MyIdx >= posx)) begin
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key_q   = key_r;
  assign hit_key = (MyIdx == posx) ? key_r : '0;

endmodule

/* design/pirl_ctrl.sv */
// Request decoder: checks bounds, forms the cell command and the result beat.
// Depends on pirl_pkg for codes, command and result types.
module pirl_ctrl #(
  parameter int unsigned DEPTH = pirl_pkg::DEPTH_DEF,
  parameter int unsigned CW    = 7,
  parameter int unsigned AW    = 8
) (
  input  logic                       go,
  input  logic [pirl_pkg::OPC_W-1:0] opcode,
  input  logic [pirl_pkg::POS_W-1:0] position,
  input  pirl_pkg::key_t             key_in,
  input  logic [CW-1:0]              count_r,
  input  pirl_pkg::key_t             rd_key,
  output logic [CW-1:0]              count_nxt,
  output pirl_pkg::cmd_t             cmd,
  output pirl_pkg::res_t             res
);
  import pirl_pkg::*;

  localparam logic [CW-1:0] Full = CW'(DEPTH);

  logic [AW-1:0] posx;
  logic [AW-1:0] cntx;
  logic          ins_ok;
  logic          rem_ok;

  assign posx = AW'(position);
  assign cntx = AW'(count_r);

  always_comb begin
    ins_ok           = 1'b0;
    rem_ok           = 1'b0;
    count_nxt        = count_r;
    res.key_out      = '0;
    res.position_out = '0;
    res.status       = ST_OK;
    case (opcode)
      OP_INSERT: begin
        if (count_r == Full) begin
          res.status = ST_FULL;
        end else if (posx > cntx) begin
          res.status = ST_RANGE;
        end else begin
          ins_ok           = 1'b1;
          count_nxt        = count_r + CW'(1);
          res.position_out = position;
        end
      end
      OP_REMOVE: begin
        if (posx >= cntx) begin
          res.status = ST_RANGE;
        end else begin
          rem_ok           = 1'b1;
          count_nxt        = count_r - CW'(1);
          res.position_out = position;
        end
      end
      OP_INSPECT: begin
        if (posx >= cntx) begin
          res.status = ST_RANGE;
        end else begin
          res.key_out = rd_key;
        end
      end
      default: begin
      end
    endcase
    res.count    = CNT_W'(count_nxt);
    res.is_empty = (count_nxt == '0);
  end

  assign cmd.ins_en = go && ins_ok;
  assign cmd.rem_en = go && rem_ok;
  assign cmd.pos    = position;
  assign cmd.key    = key_in;

endmodule

/* design/positional_insert_remove_list.sv */
// Top level of the positional insert/remove list: a chain of DEPTH key cells,
// the request decoder and a registered result stage. Depends on pirl_pkg,
// pirl_if, pirl_cell and pirl_ctrl.
//
// The list keeps up to DEPTH signed 32-bit keys in a row of cells. Every cell
// sees the same command and decides by its own index whether to take its left
// neighbor's key (insert), its right neighbor's key (remove), the new key, or
// to hold, so an insert or remove of any position updates all cells at once.
// Each request beat gives one result beat in the next cycle; a new request is
// taken whenever the result register is empty or being drained, so with the
// output ready held high the sustained rate is one request per cycle. Inspect
// reads the requested cell through an OR of the per-cell selects. Keys need
// no clearing after reset; only the entry count and result valid are reset.
module positional_insert_remove_list #(
  parameter int unsigned DEPTH = pirl_pkg::DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  pirl_in_if.sink    in_ch,
  pirl_out_if.source out_ch
);
  import pirl_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          out_valid_r;
  res_t          res_r;
  res_t          res;
  cmd_t          cmd;
  key_t          rd_key;
  logic          go;

  key_t cell_key [DEPTH];
  key_t cell_hit [DEPTH];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign go          = in_ch.valid && in_ch.ready;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      key_t left_k;
      key_t right_k;
      if (g == 0) begin : g_first
        assign left_k = '0;
      end else begin : g_mid_l
        assign left_k = cell_key[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign right_k = '0;
      end else begin : g_mid_r
        assign right_k = cell_key[g+1];
      end
      pirl_cell #(
        .IDX (g),
        .AW  (AW)
      ) u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .left_key  (left_k),
        .right_key (right_k),
        .key_q     (cell_key[g]),
        .hit_key   (cell_hit[g])
      );
    end
  endgenerate

  always_comb begin
    rd_key = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_key = rd_key | cell_hit[i];
    end
  end

  pirl_ctrl #(
    .DEPTH (DEPTH),
    .CW    (CW),
    .AW    (AW)
  ) u_ctrl (
    .go        (go),
    .opcode    (in_ch.opcode),
    .position  (in_ch.position),
    .key_in    (in_ch.key_in),
    .count_r   (count_r),
    .rd_key    (rd_key),
    .count_nxt (count_nxt),
    .cmd       (cmd),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (go) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.key_out      = res_r.key_out;
  assign out_ch.position_out = res_r.position_out;
  assign out_ch.count        = res_r.count;
  assign out_ch.is_empty     = res_r.is_empty;
  assign out_ch.status       = res_r.status;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("Entry count exceeds the list depth.");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    go && cmd.ins_en |=> count_r == $past(count_r) + CW'(1))
    else $error("Accepted insert did not grow the list by one.");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.status != ST_OK) |->
      (res_r.key_out == '0) && (res_r.position_out == '0))
    else $error("Failed request returned a nonzero key or position.");

  a_empty_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> res_r.is_empty == (res_r.count == '0))
    else $error("Empty flag disagrees with the reported count.");

endmodule
